// File: sv/roc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// roc_pkg
// Shared constants, types and state encodings for the percent rate-of-change
// block with latched sign alert.
// ----------------------------------------------------------------------------
package roc_pkg;

   // delay line
   localparam int MAX_PERIOD = 256;
   localparam int ADDR_W     = $clog2(MAX_PERIOD);
   localparam int FILL_W     = $clog2(MAX_PERIOD + 1);
   localparam int PERIOD_W   = 9;
   localparam int LAG_W      = (FILL_W > PERIOD_W) ? FILL_W : PERIOD_W;
   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 9'd14;

   // item fields
   localparam int SAMPLE_W = 32;
   localparam int RATE_W   = 32;
   localparam int ALERT_W  = 2;
   localparam logic [RATE_W-1:0] RATE_MAX = {1'b0, {(RATE_W-1){1'b1}}};
   localparam logic [RATE_W-1:0] RATE_MIN = {1'b1, {(RATE_W-1){1'b0}}};

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // divider: 100 * 2^16 = 25 * 2^18, dividend is |n-o| * 25 shifted by 18
   localparam int DIFF_W      = SAMPLE_W + 1;
   localparam int MAG_W       = SAMPLE_W + 1;
   localparam int SCALED_W    = MAG_W + 5;
   localparam int SCALE_SHIFT = 18;
   localparam int DIVIDEND_W  = SCALED_W + SCALE_SHIFT;
   localparam int DIVISOR_W   = SAMPLE_W;
   localparam int QUOT_W      = RATE_W + 1;
   localparam int HI_W        = DIVIDEND_W - QUOT_W;
   localparam int CNT_W       = $clog2(QUOT_W + 1);

   typedef enum logic [ALERT_W-1:0] {
      SIGN_NONE = 2'd0,
      SIGN_RISE = 2'd1,
      SIGN_FALL = 2'd2
   } sign_type;

   typedef struct packed {
      logic                       rate_valid;
      logic signed [SAMPLE_W-1:0] new_value;
      logic signed [SAMPLE_W-1:0] old_value;
   } roc_job_type;

   typedef enum logic {
      FR_IDLE,
      FR_PUSH
   } front_state_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_ABS,
      BK_SCALE,
      BK_DIV,
      BK_SAT,
      BK_OUT
   } back_state_type;

endpackage
`default_nettype wire

// File: sv/roc_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// roc_req_if
// Sample channel: valid/ready handshake carrying one signed Q16.16 sample.
// ----------------------------------------------------------------------------
interface roc_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [roc_pkg::SAMPLE_W-1:0] sample_value;

   modport source (output valid, output sample_value, input ready);
   modport sink   (input valid, input sample_value, output ready);
endinterface
`default_nettype wire

// File: sv/roc_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// roc_rsp_if
// Result channel: valid/ready handshake carrying rate, flags and alert.
// ----------------------------------------------------------------------------
interface roc_rsp_if;
   logic                               valid;
   logic                               ready;
   logic                               rate_valid;
   logic signed [roc_pkg::RATE_W-1:0]  rate_percent;
   logic                               divide_by_zero;
   logic        [roc_pkg::ALERT_W-1:0] alert_status;

   modport source (output valid, output rate_valid, output rate_percent,
                   output divide_by_zero, output alert_status, input ready);
   modport sink   (input valid, input rate_valid, input rate_percent,
                   input divide_by_zero, input alert_status, output ready);
endinterface
`default_nettype wire

// File: sv/roc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// roc_front
// Accepts samples, keeps the circular delay line, looks up the lagged sample
// and classifies each item as full or not yet full before queuing it.
// ----------------------------------------------------------------------------
module roc_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_write_enable,
   input  wire logic [roc_pkg::PERIOD_W-1:0]  csr_write_data,
   roc_req_if.sink                            req,
   output      logic                          push_valid,
   input  wire logic                          push_ready,
   output      roc_pkg::roc_job_type          push_job
);

   roc_pkg::front_state_type state_ff, state_in;

   logic [roc_pkg::PERIOD_W-1:0] period_ff, period_in;
   logic [roc_pkg::ADDR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [roc_pkg::FILL_W-1:0]   fill_ff, fill_in;
   logic                         job_valid_ff, job_valid_in;
   logic [roc_pkg::SAMPLE_W-1:0] new_ff, new_in;
   logic [roc_pkg::SAMPLE_W-1:0] rd_data_ff;

   logic [roc_pkg::SAMPLE_W-1:0] delay_line_mem [roc_pkg::MAX_PERIOD];

   logic                         accept;
   logic [roc_pkg::LAG_W-1:0]    lag;
   logic                         full;
   logic [roc_pkg::LAG_W:0]      wp_wide;
   logic [roc_pkg::LAG_W:0]      lag_wide;
   logic [roc_pkg::LAG_W:0]      rd_sum;
   logic [roc_pkg::ADDR_W-1:0]   rd_addr;

   assign accept = req.valid && req.ready;

   // a period of zero acts as one, above the line length it is clamped
   always_comb begin
      lag = roc_pkg::LAG_W'(period_ff);
      if (period_ff == '0) begin
         lag = roc_pkg::LAG_W'(1);
      end else if (roc_pkg::LAG_W'(period_ff) > roc_pkg::LAG_W'(roc_pkg::MAX_PERIOD)) begin
         lag = roc_pkg::LAG_W'(roc_pkg::MAX_PERIOD);
      end
   end

   assign full     = roc_pkg::LAG_W'(fill_ff) >= lag;
   assign wp_wide  = (roc_pkg::LAG_W+1)'(wr_ptr_ff);
   assign lag_wide = (roc_pkg::LAG_W+1)'(lag);
   assign rd_sum   = (wp_wide >= lag_wide) ? wp_wide - lag_wide
                   : wp_wide + (roc_pkg::LAG_W+1)'(roc_pkg::MAX_PERIOD) - lag_wide;
   assign rd_addr  = rd_sum[roc_pkg::ADDR_W-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         roc_pkg::FR_IDLE: begin
            if (accept) state_in = roc_pkg::FR_PUSH;
         end
         roc_pkg::FR_PUSH: begin
            if (push_ready) state_in = roc_pkg::FR_IDLE;
         end
         default: state_in = roc_pkg::FR_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req.ready  = 1'b0;
      push_valid = 1'b0;
      case (state_ff)
         roc_pkg::FR_IDLE: req.ready  = 1'b1;
         roc_pkg::FR_PUSH: push_valid = 1'b1;
         default: begin
            req.ready  = 1'b0;
            push_valid = 1'b0;
         end
      endcase
   end

   always_comb begin
      period_in    = csr_write_enable ? csr_write_data : period_ff;
      wr_ptr_in    = wr_ptr_ff;
      fill_in      = fill_ff;
      job_valid_in = job_valid_ff;
      new_in       = new_ff;
      if (accept) begin
         wr_ptr_in    = (wr_ptr_ff == roc_pkg::ADDR_W'(roc_pkg::MAX_PERIOD - 1)) ? '0
                      : wr_ptr_ff + roc_pkg::ADDR_W'(1);
         if (fill_ff != roc_pkg::FILL_W'(roc_pkg::MAX_PERIOD)) begin
            fill_in = fill_ff + roc_pkg::FILL_W'(1);
         end
         job_valid_in = full;
         new_in       = req.sample_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= roc_pkg::FR_IDLE;
         period_ff <= roc_pkg::PERIOD_RESET;
         wr_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         period_ff <= period_in;
         wr_ptr_ff <= wr_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      job_valid_ff <= job_valid_in;
      new_ff       <= new_in;
   end

   // read before write, so a full-length lag still sees the old entry
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_data_ff                <= delay_line_mem[rd_addr];
         delay_line_mem[wr_ptr_ff] <= req.sample_value;
      end
   end

   assign push_job = '{rate_valid: job_valid_ff,
                       new_value:  new_ff,
                       old_value:  rd_data_ff};

`ifndef SYNTHESIS
   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= roc_pkg::FILL_W'(roc_pkg::MAX_PERIOD))
      else $error("fill count beyond delay line length");

   a_ptr_bounded: assert property (@(posedge clock) disable iff (reset)
      roc_pkg::LAG_W'(wr_ptr_ff) < roc_pkg::LAG_W'(roc_pkg::MAX_PERIOD))
      else $error("write pointer beyond delay line");
`endif

endmodule
`default_nettype wire

// File: sv/roc_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// roc_queue
// Short first-in first-out queue of classified items between front and back.
// ----------------------------------------------------------------------------
module roc_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push_valid,
   output      logic                 push_ready,
   input  wire roc_pkg::roc_job_type push_job,
   output      logic                 pop_valid,
   input  wire logic                 pop_ready,
   output      roc_pkg::roc_job_type pop_job
);

   roc_pkg::roc_job_type        entries_ff [roc_pkg::QUEUE_DEPTH];
   logic [roc_pkg::QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [roc_pkg::QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [roc_pkg::QCNT_W-1:0]  count_ff, count_in;
   logic                        push, pop;

   assign push_ready = count_ff != roc_pkg::QCNT_W'(roc_pkg::QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_job    = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == roc_pkg::QPTR_W'(roc_pkg::QUEUE_DEPTH - 1)) ? '0
                   : wr_ptr_ff + roc_pkg::QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == roc_pkg::QPTR_W'(roc_pkg::QUEUE_DEPTH - 1)) ? '0
                   : rd_ptr_ff + roc_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + roc_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - roc_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule
`default_nettype wire

// File: sv/roc_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// roc_back
// Works out the saturated percent change with a radix-2 restoring divider,
// latches the sign status and holds the result in the output register.
// ----------------------------------------------------------------------------
module roc_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 pop_valid,
   output      logic                 pop_ready,
   input  wire roc_pkg::roc_job_type pop_job,
   roc_rsp_if.source                 rsp
);

   roc_pkg::back_state_type state_ff, state_in;

   roc_pkg::roc_job_type          job_ff, job_in;
   logic                          neg_ff, neg_in;
   logic                          zero_ff, zero_in;
   logic                          ovf_ff, ovf_in;
   logic [roc_pkg::MAG_W-1:0]     dm_ff, dm_in;
   logic [roc_pkg::DIVISOR_W-1:0] om_ff, om_in;
   logic [roc_pkg::DIVISOR_W-1:0] rem_ff, rem_in;
   logic [roc_pkg::QUOT_W-1:0]    quot_ff, quot_in;
   logic [roc_pkg::CNT_W-1:0]     cnt_ff, cnt_in;
   roc_pkg::sign_type             sign_ff, sign_in;

   logic                          res_valid_ff, res_valid_in;
   logic [roc_pkg::RATE_W-1:0]    res_rate_ff, res_rate_in;
   logic                          res_dbz_ff, res_dbz_in;
   roc_pkg::sign_type             res_alert_ff, res_alert_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_rate_valid_ff;
   logic [roc_pkg::RATE_W-1:0]    rsp_rate_ff;
   logic                          rsp_dbz_ff;
   roc_pkg::sign_type             rsp_alert_ff;

   logic                          load_out;

   logic [roc_pkg::SAMPLE_W-1:0]   n_bits, o_bits;
   logic [roc_pkg::DIFF_W-1:0]     diff;
   logic [roc_pkg::SCALED_W-1:0]   scaled;
   logic [roc_pkg::DIVIDEND_W-1:0] dividend;
   logic [roc_pkg::HI_W-1:0]       dividend_hi;
   logic [roc_pkg::DIVISOR_W+1:0]  trial;
   logic [roc_pkg::DIVISOR_W:0]    shifted;
   logic                           sat_hit;
   logic [roc_pkg::RATE_W-1:0]     rate;

   assign n_bits = job_ff.new_value;
   assign o_bits = job_ff.old_value;

   // sign-extended difference, then magnitudes
   assign diff = {n_bits[roc_pkg::SAMPLE_W-1], n_bits}
               - {o_bits[roc_pkg::SAMPLE_W-1], o_bits};

   // times 25 by shift and add
   assign scaled = (roc_pkg::SCALED_W'(dm_ff) << 4) + (roc_pkg::SCALED_W'(dm_ff) << 3)
                 + roc_pkg::SCALED_W'(dm_ff);
   assign dividend    = {scaled, {roc_pkg::SCALE_SHIFT{1'b0}}};
   assign dividend_hi = dividend[roc_pkg::DIVIDEND_W-1 -: roc_pkg::HI_W];

   assign shifted = {rem_ff, quot_ff[roc_pkg::QUOT_W-1]};
   assign trial   = {1'b0, shifted} - {2'b00, om_ff};

   assign sat_hit = ovf_ff || (quot_ff[roc_pkg::QUOT_W-1:roc_pkg::RATE_W-1] != '0);

   always_comb begin
      rate = '0;
      if (!job_ff.rate_valid) begin
         rate = '0;
      end else if (zero_ff) begin
         if (n_bits[roc_pkg::SAMPLE_W-1]) begin
            rate = roc_pkg::RATE_MIN;
         end else if (n_bits != '0) begin
            rate = roc_pkg::RATE_MAX;
         end
      end else if (sat_hit) begin
         rate = neg_ff ? roc_pkg::RATE_MIN : roc_pkg::RATE_MAX;
      end else if (neg_ff) begin
         rate = roc_pkg::RATE_W'(0) - quot_ff[roc_pkg::RATE_W-1:0];
      end else begin
         rate = quot_ff[roc_pkg::RATE_W-1:0];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         roc_pkg::BK_IDLE: begin
            if (pop_valid) state_in = roc_pkg::BK_ABS;
         end
         roc_pkg::BK_ABS: state_in = roc_pkg::BK_SCALE;
         roc_pkg::BK_SCALE: begin
            if (!job_ff.rate_valid || zero_ff
                || ({{(roc_pkg::DIVISOR_W-roc_pkg::HI_W){1'b0}}, dividend_hi} >= om_ff)) begin
               state_in = roc_pkg::BK_SAT;
            end else begin
               state_in = roc_pkg::BK_DIV;
            end
         end
         roc_pkg::BK_DIV: begin
            if (cnt_ff == roc_pkg::CNT_W'(1)) state_in = roc_pkg::BK_SAT;
         end
         roc_pkg::BK_SAT: state_in = roc_pkg::BK_OUT;
         roc_pkg::BK_OUT: begin
            if (!rsp_valid_ff || rsp.ready) state_in = roc_pkg::BK_IDLE;
         end
         default: state_in = roc_pkg::BK_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      pop_ready = 1'b0;
      load_out  = 1'b0;
      case (state_ff)
         roc_pkg::BK_IDLE: pop_ready = 1'b1;
         roc_pkg::BK_OUT:  load_out  = !rsp_valid_ff || rsp.ready;
         default: begin
            pop_ready = 1'b0;
            load_out  = 1'b0;
         end
      endcase
   end

   // datapath
   always_comb begin
      job_in       = job_ff;
      neg_in       = neg_ff;
      zero_in      = zero_ff;
      ovf_in       = ovf_ff;
      dm_in        = dm_ff;
      om_in        = om_ff;
      rem_in       = rem_ff;
      quot_in      = quot_ff;
      cnt_in       = cnt_ff;
      sign_in      = sign_ff;
      res_valid_in = res_valid_ff;
      res_rate_in  = res_rate_ff;
      res_dbz_in   = res_dbz_ff;
      res_alert_in = res_alert_ff;
      case (state_ff)
         roc_pkg::BK_IDLE: begin
            if (pop_valid) job_in = pop_job;
         end
         roc_pkg::BK_ABS: begin
            neg_in  = diff[roc_pkg::DIFF_W-1] != o_bits[roc_pkg::SAMPLE_W-1];
            dm_in   = diff[roc_pkg::DIFF_W-1] ? roc_pkg::MAG_W'(0) - diff : diff;
            om_in   = o_bits[roc_pkg::SAMPLE_W-1] ? roc_pkg::DIVISOR_W'(0) - o_bits : o_bits;
            zero_in = o_bits == '0;
         end
         roc_pkg::BK_SCALE: begin
            // quotient of 2^33 or more saturates, no need to divide
            ovf_in  = {{(roc_pkg::DIVISOR_W-roc_pkg::HI_W){1'b0}}, dividend_hi} >= om_ff;
            rem_in  = roc_pkg::DIVISOR_W'(dividend_hi);
            quot_in = dividend[roc_pkg::QUOT_W-1:0];
            cnt_in  = roc_pkg::CNT_W'(roc_pkg::QUOT_W);
         end
         roc_pkg::BK_DIV: begin
            if (!trial[roc_pkg::DIVISOR_W+1]) begin
               rem_in = trial[roc_pkg::DIVISOR_W-1:0];
            end else begin
               rem_in = shifted[roc_pkg::DIVISOR_W-1:0];
            end
            quot_in = {quot_ff[roc_pkg::QUOT_W-2:0], !trial[roc_pkg::DIVISOR_W+1]};
            cnt_in  = cnt_ff - roc_pkg::CNT_W'(1);
         end
         roc_pkg::BK_SAT: begin
            res_valid_in = job_ff.rate_valid;
            res_rate_in  = rate;
            res_dbz_in   = job_ff.rate_valid && zero_ff;
            res_alert_in = roc_pkg::SIGN_NONE;
            if (job_ff.rate_valid) begin
               // zero rate holds the latched sign
               if (rate[roc_pkg::RATE_W-1]) begin
                  sign_in      = roc_pkg::SIGN_FALL;
                  res_alert_in = roc_pkg::SIGN_FALL;
               end else if (rate != '0) begin
                  sign_in      = roc_pkg::SIGN_RISE;
                  res_alert_in = roc_pkg::SIGN_RISE;
               end else begin
                  res_alert_in = sign_ff;
               end
            end
         end
         default: begin
            job_in = job_ff;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= roc_pkg::BK_IDLE;
         sign_ff      <= roc_pkg::SIGN_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sign_ff      <= sign_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff       <= job_in;
      neg_ff       <= neg_in;
      zero_ff      <= zero_in;
      ovf_ff       <= ovf_in;
      dm_ff        <= dm_in;
      om_ff        <= om_in;
      rem_ff       <= rem_in;
      quot_ff      <= quot_in;
      cnt_ff       <= cnt_in;
      res_valid_ff <= res_valid_in;
      res_rate_ff  <= res_rate_in;
      res_dbz_ff   <= res_dbz_in;
      res_alert_ff <= res_alert_in;
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_rate_valid_ff <= res_valid_ff;
         rsp_rate_ff       <= res_rate_ff;
         rsp_dbz_ff        <= res_dbz_ff;
         rsp_alert_ff      <= res_alert_ff;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.rate_valid     = rsp_rate_valid_ff;
   assign rsp.rate_percent   = rsp_rate_ff;
   assign rsp.divide_by_zero = rsp_dbz_ff;
   assign rsp.alert_status   = rsp_alert_ff;

`ifndef SYNTHESIS
   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      state_ff == roc_pkg::BK_DIV |-> rem_ff < om_ff && cnt_ff != '0)
      else $error("divider remainder not below divisor");

   a_not_full_result: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.rate_valid |->
         rsp.rate_percent == '0 && !rsp.divide_by_zero
         && rsp.alert_status == roc_pkg::SIGN_NONE)
      else $error("result before delay line full carries data");

   a_sign_follows_rate: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.rate_valid && rsp.rate_percent != '0 |->
         rsp.alert_status == (rsp.rate_percent[roc_pkg::RATE_W-1] ? roc_pkg::SIGN_FALL
                                                                 : roc_pkg::SIGN_RISE))
      else $error("alert status disagrees with rate sign");

   a_dbz_needs_valid: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.divide_by_zero |-> rsp.rate_valid)
      else $error("divide flag on a result with no rate");
`endif

endmodule
`default_nettype wire

// File: sv/rate_of_change_with_sign_alert.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rate_of_change_with_sign_alert
// Percent rate of change of a Q16.16 series against the sample one period
// back, saturated, with a latched rising/falling alert.
// ----------------------------------------------------------------------------
//  channel | direction | handshake      | payload
//  req     | in        | valid / ready  | sample_value
//  rsp     | out       | valid / ready  | rate_valid, rate_percent,
//          |           |                | divide_by_zero, alert_status
//  csr     | in        | write enable   | period (9 bits)
//
//  in the back end an item is taken from the queue, then passes through
//  magnitude, scaling, the 33 steps of the radix-2 divider, saturation
//  and output load in that order; the divide is skipped when the delay
//  line is not yet full, the lagged sample is zero or the quotient is
//  2^33 or more. the front takes no new sample until its item is queued.
//  reset clears pointers, fill count, sign status and sets the period to 14;
//  the delay line is not cleared, and a lagged entry is used only once written.
//  a two-entry queue separates front and back, and the output register
//  holds a result while rsp is stalled so the back can take the next item.
// ----------------------------------------------------------------------------
module rate_of_change_with_sign_alert (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_write_enable,
   input  wire logic [roc_pkg::PERIOD_W-1:0]  csr_write_data,
   roc_req_if.sink                            req,
   roc_rsp_if.source                          rsp
);

   logic                 push_valid;
   logic                 push_ready;
   roc_pkg::roc_job_type push_job;
   logic                 pop_valid;
   logic                 pop_ready;
   roc_pkg::roc_job_type pop_job;

   roc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req              (req),
      .push_valid       (push_valid),
      .push_ready       (push_ready),
      .push_job         (push_job)
   );

   roc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   roc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_job   (pop_job),
      .rsp       (rsp)
   );

endmodule
`default_nettype wire

// File: tb/sv/tb_rate_of_change_with_sign_alert.sv
// ----------------------------------------------------------------------------
// tb_rate_of_change_with_sign_alert
// Self-checking bench for the percent rate-of-change block. A short table of
// directed samples and lag settings is followed by random series, each
// result checked against a table entry or an in-bench model of the delay
// line, the saturated percent divide and the latched sign. Both channels
// idle and stall at random; one long result hold-off backs the block up.
// ----------------------------------------------------------------------------
module tb_rate_of_change_with_sign_alert;
   timeunit 1ns;
   timeprecision 1ps;

   import roc_pkg::*;

   localparam int                  ITEMS_PER_PHASE = 130;
   localparam int                  PHASE_COUNT     = 10;
   localparam int                  HOLD_CYCLES     = 600;
   localparam int                  WATCHDOG_LIMIT  = 5000;
   localparam int                  SETTLE_CYCLES   = 60;
   localparam int                  MAX_REPORTS     = 10;
   localparam longint unsigned     PERCENT_SCALE   = 64'd6553600;
   localparam logic [PERIOD_W-1:0] PHASE_PERIODS [PHASE_COUNT] = '{
      9'd1, 9'd2, 9'd14, 9'd256, 9'd511, 9'd0, 9'd5, 9'd100, 9'd255, 9'd3
   };

   typedef struct packed {
      logic                     rate_valid;
      logic signed [RATE_W-1:0] rate_percent;
      logic                     divide_by_zero;
      sign_type                 alert_status;
   } rate_result_type;

   typedef enum logic {
      ROW_SAMPLE,
      ROW_PERIOD
   } row_kind_type;

   typedef struct packed {
      row_kind_type         kind;
      logic [SAMPLE_W-1:0]  data;
      logic                 check_typed;
      rate_result_type      result;
   } directed_row_type;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_RANDOM,
      STALL_PERIODIC,
      STALL_RARE
   } stall_mode_type;

   localparam rate_result_type NOT_FULL  = '{1'b0, '0, 1'b0, SIGN_NONE};
   localparam rate_result_type UNTYPED   = '0;

   localparam int DIRECTED_COUNT = 23;
   localparam directed_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      '{ROW_SAMPLE, 32'h0001_0000, 1'b1, NOT_FULL},
      '{ROW_SAMPLE, 32'hFFFF_0000, 1'b1, NOT_FULL},
      '{ROW_PERIOD, 32'd0,         1'b0, UNTYPED},
      '{ROW_SAMPLE, 32'h0000_0000, 1'b0, UNTYPED},
      '{ROW_SAMPLE, 32'h7FFF_FFFF, 1'b1, '{1'b1, RATE_MAX, 1'b1, SIGN_RISE}},
      '{ROW_SAMPLE, 32'h8000_0000, 1'b0, UNTYPED},
      '{ROW_SAMPLE, 32'h0000_0000, 1'b0, UNTYPED},
      '{ROW_SAMPLE, 32'h0000_0000, 1'b1, '{1'b1, '0, 1'b1, SIGN_FALL}},
      '{ROW_SAMPLE, 32'h8000_0000, 1'b1, '{1'b1, RATE_MIN, 1'b1, SIGN_FALL}},
      '{ROW_SAMPLE, 32'h0000_0000, 1'b0, UNTYPED},
      '{ROW_SAMPLE, 32'h0000_0001, 1'b1, '{1'b1, RATE_MAX, 1'b1, SIGN_RISE}},
      '{ROW_SAMPLE, 32'h0000_0001, 1'b1, '{1'b1, '0, 1'b0, SIGN_RISE}},
      '{ROW_SAMPLE, 32'h7FFF_FFFF, 1'b1, '{1'b1, RATE_MAX, 1'b0, SIGN_RISE}},
      '{ROW_SAMPLE, 32'h7FFF_FFFE, 1'b0, UNTYPED},
      '{ROW_SAMPLE, 32'hFFFF_FFFF, 1'b0, UNTYPED},
      '{ROW_SAMPLE, 32'h0000_0001, 1'b0, UNTYPED},
      '{ROW_SAMPLE, 32'h8000_0000, 1'b1, '{1'b1, RATE_MIN, 1'b0, SIGN_FALL}},
      '{ROW_SAMPLE, 32'hFFFF_FFFF, 1'b0, UNTYPED},
      '{ROW_PERIOD, 32'd511,       1'b0, UNTYPED},
      '{ROW_SAMPLE, 32'h0001_8000, 1'b1, NOT_FULL},
      '{ROW_PERIOD, 32'd2,         1'b0, UNTYPED},
      '{ROW_SAMPLE, 32'h0001_8000, 1'b0, UNTYPED},
      '{ROW_SAMPLE, 32'h0000_C000, 1'b0, UNTYPED}
   };

   logic                clock;
   logic                reset;
   logic                csr_write_enable;
   logic [PERIOD_W-1:0] csr_write_data;

   roc_req_if req_if ();
   roc_rsp_if rsp_if ();

   rate_of_change_with_sign_alert u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req              (req_if),
      .rsp              (rsp_if)
   );

   // model state
   logic [SAMPLE_W-1:0] lag_history [MAX_PERIOD];
   logic [ADDR_W-1:0]   history_ptr;
   logic [FILL_W-1:0]   history_fill;
   sign_type            latched_sign;
   logic [PERIOD_W-1:0] period_setting;
   logic [SAMPLE_W-1:0] series_level;

   rate_result_type expected_rates [$];

   int hold_requests;
   int holds_served;
   int failures;
   int results_checked;
   int samples_sent;
   int valid_rates;
   int zero_lag_divides;
   int saturated_rates;
   int lag_settings;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic rate_result_type predict_rate(input logic [SAMPLE_W-1:0] raw);
      int unsigned       lag;
      logic [ADDR_W-1:0] idx;
      longint            n, o, d;
      longint unsigned   dm, om, q;
      rate_result_type   r;
      r   = '0;
      lag = (period_setting == 0) ? 1 :
            (period_setting > MAX_PERIOD) ? MAX_PERIOD : period_setting;
      n   = $signed(raw);
      if (history_fill >= lag) begin
         // a lag of the full depth wraps back onto the write slot
         idx          = history_ptr - lag[ADDR_W-1:0];
         o            = $signed(lag_history[idx]);
         r.rate_valid = 1'b1;
         if (o == 0) begin
            r.divide_by_zero = 1'b1;
            if (n > 0) r.rate_percent = RATE_MAX;
            else if (n < 0) r.rate_percent = RATE_MIN;
         end else begin
            d  = n - o;
            dm = (d < 0) ? -d : d;
            om = (o < 0) ? -o : o;
            q  = (dm * PERCENT_SCALE) / om;
            if (q == 0) r.rate_percent = '0;
            else if ((d < 0) != (o < 0))
               r.rate_percent = (q >= 64'h8000_0000) ? RATE_MIN : -q[RATE_W-1:0];
            else
               r.rate_percent = (q > 64'h7FFF_FFFF) ? RATE_MAX : q[RATE_W-1:0];
         end
         if (r.rate_percent > 0) latched_sign = SIGN_RISE;
         else if (r.rate_percent < 0) latched_sign = SIGN_FALL;
         r.alert_status = latched_sign;
      end
      lag_history[history_ptr] = raw;
      history_ptr              = history_ptr + 1'b1;
      if (history_fill < MAX_PERIOD) history_fill = history_fill + 1'b1;
      return r;
   endfunction

   // mostly a drifting series, with zeros, extremes and jumps mixed in
   function automatic logic [SAMPLE_W-1:0] next_series_sample();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
         series_level = series_level + SAMPLE_W'($urandom_range(0, 32'h3_FFFF))
                        - SAMPLE_W'(32'h2_0000);
      end else if (pick < 60) begin
         return series_level;
      end else if (pick < 68) begin
         return '0;
      end else if (pick < 76) begin
         case ($urandom_range(0, 3))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0001;
            default: return 32'hFFFF_FFFF;
         endcase
      end else if (pick < 86) begin
         series_level = SAMPLE_W'($urandom_range(0, 32'h0020_0000)) - SAMPLE_W'(32'h0010_0000);
      end else begin
         series_level = $urandom;
      end
      return series_level;
   endfunction

   task automatic send_sample(input logic [SAMPLE_W-1:0] value, input logic check_typed,
                              input rate_result_type typed_result);
      rate_result_type predicted;
      req_if.valid        <= 1'b1;
      req_if.sample_value <= value;
      @(posedge clock);
      while (req_if.ready !== 1'b1) @(posedge clock);
      predicted = predict_rate(value);
      expected_rates.push_back(check_typed ? typed_result : predicted);
      samples_sent++;
      if (predicted.rate_valid) valid_rates++;
      if (predicted.divide_by_zero) zero_lag_divides++;
      if (predicted.rate_valid && !predicted.divide_by_zero &&
          (predicted.rate_percent == RATE_MAX || predicted.rate_percent == RATE_MIN))
         saturated_rates++;
   endtask

   task automatic idle_sender(input int cycles);
      req_if.valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic drain_results();
      req_if.valid <= 1'b0;
      while (expected_rates.size() != 0) @(posedge clock);
   endtask

   task automatic write_period(input logic [PERIOD_W-1:0] value);
      drain_results();
      repeat (2) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      period_setting    = value;
      lag_settings++;
   endtask

   // sender: directed table, then random series in bursts
   initial begin
      logic [PERIOD_W-1:0] period_choice;
      int                  gap_limit;
      int                  burst_left;
      reset               <= 1'b1;
      csr_write_enable    <= 1'b0;
      csr_write_data      <= '0;
      req_if.valid        <= 1'b0;
      req_if.sample_value <= '0;
      history_ptr          = '0;
      history_fill         = '0;
      latched_sign         = SIGN_NONE;
      period_setting       = PERIOD_RESET;
      series_level         = $urandom;
      hold_requests        = 0;
      samples_sent         = 0;
      valid_rates          = 0;
      zero_lag_divides     = 0;
      saturated_rates      = 0;
      lag_settings         = 1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[i]) begin
         if (DIRECTED_ROWS[i].kind == ROW_PERIOD)
            write_period(DIRECTED_ROWS[i].data[PERIOD_W-1:0]);
         else
            send_sample(DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].check_typed,
                        DIRECTED_ROWS[i].result);
      end

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         period_choice = (phase == PHASE_COUNT - 1) ? PERIOD_W'($urandom_range(1, 300))
                                                    : PHASE_PERIODS[phase];
         write_period(period_choice);
         case (phase % 3)
            0: gap_limit = 0;
            1: gap_limit = 4;
            default: gap_limit = 60;
         endcase
         burst_left = 0;
         for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
            // long result hold-off while transfers keep being offered
            if (phase == 2 && k == 40) hold_requests++;
            if (phase == 6 && k == 60) drain_results();
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               if (gap_limit != 0) idle_sender($urandom_range(1, gap_limit));
            end
            send_sample(next_series_sample(), 1'b0, UNTYPED);
            burst_left--;
         end
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("covered %0d samples over %0d lag settings, %0d results checked",
               samples_sent, lag_settings, results_checked);
      $display("%0d valid rates, %0d zero-lag divides, %0d saturated; %0d failures",
               valid_rates, zero_lag_divides, saturated_rates, failures);
      if (failures == 0 && expected_rates.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // receiver: changing stall pattern, plus the long hold-off on request
   initial begin
      stall_mode_type stall_mode;
      int             mode_left;
      int             cycle_count;
      stall_mode     = STALL_NONE;
      mode_left      = 0;
      cycle_count    = 0;
      holds_served   = 0;
      rsp_if.ready  <= 1'b0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (holds_served < hold_requests) begin
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            holds_served++;
         end
         if (mode_left == 0) begin
            stall_mode = stall_mode_type'($urandom_range(0, 3));
            mode_left  = $urandom_range(50, 300);
         end
         mode_left--;
         case (stall_mode)
            STALL_NONE:     rsp_if.ready <= 1'b1;
            STALL_RANDOM:   rsp_if.ready <= 1'($urandom_range(0, 1));
            STALL_PERIODIC: rsp_if.ready <= (cycle_count % 4 == 0);
            default:        rsp_if.ready <= ($urandom_range(0, 9) != 0);
         endcase
      end
   end

   // result checking against the oldest expectation
   initial begin
      failures        = 0;
      results_checked = 0;
   end

   always @(posedge clock) begin
      rate_result_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         results_checked++;
         if (expected_rates.size() == 0) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display("result %0d arrived with nothing expected", results_checked);
         end else begin
            want = expected_rates.pop_front();
            if (rsp_if.rate_valid !== want.rate_valid ||
                rsp_if.rate_percent !== want.rate_percent ||
                rsp_if.divide_by_zero !== want.divide_by_zero ||
                rsp_if.alert_status !== want.alert_status) begin
               failures++;
               if (failures <= MAX_REPORTS) begin
                  $display("result %0d: expected valid=%0b rate=%0d dbz=%0b alert=%0d",
                           results_checked, want.rate_valid, want.rate_percent,
                           want.divide_by_zero, want.alert_status);
                  $display("result %0d: got      valid=%0b rate=%0d dbz=%0b alert=%0d",
                           results_checked, rsp_if.rate_valid, rsp_if.rate_percent,
                           rsp_if.divide_by_zero, rsp_if.alert_status);
               end
            end
         end
      end
   end

   // ends the run once no transfer has happened for too long
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
             (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("no transfer for %0d cycles, %0d results still due",
               WATCHDOG_LIMIT, expected_rates.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// File: rate_of_change_with_sign_alert.f
sv/roc_pkg.sv
sv/roc_req_if.sv
sv/roc_rsp_if.sv
sv/roc_front.sv
sv/roc_queue.sv
sv/roc_back.sv
sv/rate_of_change_with_sign_alert.sv
tb/sv/tb_rate_of_change_with_sign_alert.sv
